// ===== rtl/core/bw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bw_pkg
// Shared types, widths and step functions of the barycentric weight pipeline.
// ----------------------------------------------------------------------------
package bw_pkg;

    localparam int COORD_W     = 16;
    localparam int DIFF_W      = COORD_W + 1;
    localparam int PROD_W      = 2 * DIFF_W;
    localparam int SUM_W       = PROD_W + 1;
    localparam int MAG_W       = PROD_W;
    localparam int REM_W       = MAG_W + 1;
    localparam int WEIGHT_FRAC = 16;
    localparam int WOUT_W      = 24;
    localparam int QUO_W       = WOUT_W;
    localparam int INT_SHIFT   = QUO_W - WEIGHT_FRAC;
    localparam int DIV_STAGES  = QUO_W;
    localparam int WSUM_W      = WOUT_W + 2;

    localparam logic [QUO_W:0] LIM_POS = (QUO_W + 1)'((64'd1 << (WOUT_W - 1)) - 64'd1);
    localparam logic [QUO_W:0] LIM_NEG = (QUO_W + 1)'(64'd1 << (WOUT_W - 1));
    localparam logic signed [WSUM_W-1:0] WEIGHT_ONE = WSUM_W'(64'd1 << WEIGHT_FRAC);
    localparam logic signed [WSUM_W-1:0] WSUM_MAX   = WSUM_W'((64'd1 << (WOUT_W - 1)) - 64'd1);
    localparam logic signed [WSUM_W-1:0] WSUM_MIN   = -WSUM_W'(64'd1 << (WOUT_W - 1));

    typedef struct packed {
        logic signed [COORD_W-1:0] ax;
        logic signed [COORD_W-1:0] ay;
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] by;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
    } t_tri;

    typedef struct packed {
        logic signed [DIFF_W-1:0] e0x;
        logic signed [DIFF_W-1:0] e0y;
        logic signed [DIFF_W-1:0] e1x;
        logic signed [DIFF_W-1:0] e1y;
        logic signed [DIFF_W-1:0] e2x;
        logic signed [DIFF_W-1:0] e2y;
    } t_diff;

    typedef struct packed {
        logic signed [PROD_W-1:0] p0;
        logic signed [PROD_W-1:0] p1;
        logic signed [PROD_W-1:0] p2;
        logic signed [PROD_W-1:0] p3;
        logic signed [PROD_W-1:0] p4;
        logic signed [PROD_W-1:0] p5;
    } t_prod;

    typedef struct packed {
        logic signed [SUM_W-1:0] d;
        logic signed [SUM_W-1:0] nb;
        logic signed [SUM_W-1:0] nc;
    } t_sums;

    typedef struct packed {
        logic [MAG_W-1:0] ud;
        logic [MAG_W-1:0] ub;
        logic [MAG_W-1:0] uc;
        logic             neg_b;
        logic             neg_c;
        logic             degen;
    } t_mags;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [QUO_W-1:0] dvd;
        logic [QUO_W-1:0] quo;
        logic             neg;
        logic             ov;
    } t_lane;

    typedef struct packed {
        t_lane            lane_b;
        t_lane            lane_c;
        logic [MAG_W-1:0] ud;
        logic             degen;
    } t_div;

    typedef struct packed {
        logic signed [WOUT_W-1:0] w;
        logic                     clip;
    } t_sat;

    typedef struct packed {
        logic signed [WOUT_W-1:0] wb;
        logic signed [WOUT_W-1:0] wc;
        logic                     clip;
        logic                     degen;
    } t_wt;

    function automatic logic [MAG_W-1:0] mag_of(logic signed [SUM_W-1:0] s);
        logic [SUM_W-1:0] t;
        t = s[SUM_W-1] ? (~s + 1'b1) : s;
        return t[MAG_W-1:0];
    endfunction

    function automatic t_lane lane_init(logic [MAG_W-1:0] un, logic [MAG_W-1:0] ud,
                                        logic neg);
        t_lane            l;
        logic [MAG_W-1:0] hi;
        hi    = un >> INT_SHIFT;
        l.rem = REM_W'(hi);
        l.dvd = {un[INT_SHIFT-1:0], {WEIGHT_FRAC{1'b0}}};
        l.quo = '0;
        l.neg = neg;
        l.ov  = (hi >= ud);
        return l;
    endfunction

    function automatic t_lane div_step(t_lane l, logic [MAG_W-1:0] ud);
        t_lane            o;
        logic [REM_W-1:0] trial;
        trial = {l.rem[REM_W-2:0], l.dvd[QUO_W-1]};
        o     = l;
        o.dvd = {l.dvd[QUO_W-2:0], 1'b0};
        if (trial >= REM_W'(ud)) begin
            o.rem = trial - REM_W'(ud);
            o.quo = {l.quo[QUO_W-2:0], 1'b1};
        end else begin
            o.rem = trial;
            o.quo = {l.quo[QUO_W-2:0], 1'b0};
        end
        return o;
    endfunction

    function automatic t_sat sat_quot(t_lane l, logic [MAG_W-1:0] ud);
        t_sat           s;
        logic           rnd;
        logic [QUO_W:0] q;
        logic [QUO_W:0] lim;
        logic [QUO_W:0] qs;
        rnd    = ({l.rem, 1'b0} >= {2'b00, ud});
        q      = {1'b0, l.quo} + (QUO_W + 1)'(rnd);
        lim    = l.neg ? LIM_NEG : LIM_POS;
        s.clip = l.ov | (q > lim);
        qs     = s.clip ? lim : q;
        s.w    = l.neg ? WOUT_W'(~qs + 1'b1) : WOUT_W'(qs);
        return s;
    endfunction

endpackage

// ===== rtl/core/bw_geom.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bw_geom
// Edge vectors, cross products, magnitudes and divider setup, five stages.
// ----------------------------------------------------------------------------
module bw_geom (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  bw_pkg::t_tri  i_tri,
    output logic          o_valid,
    input  logic          i_ready,
    output bw_pkg::t_div  o_div
);

    logic          r_v1, r_v2, r_v3, r_v4, r_v5;
    logic          rdy1, rdy2, rdy3, rdy4, rdy5;
    bw_pkg::t_diff r_diff, n_diff;
    bw_pkg::t_prod r_prod;
    bw_pkg::t_sums r_sums;
    bw_pkg::t_mags r_mags, n_mags;
    bw_pkg::t_div  r_div;

    assign rdy5    = !r_v5 || i_ready;
    assign rdy4    = !r_v4 || rdy5;
    assign rdy3    = !r_v3 || rdy4;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;
    assign o_valid = r_v5;
    assign o_div   = r_div;

    always_comb begin
        n_diff.e0x = bw_pkg::DIFF_W'(i_tri.bx) - bw_pkg::DIFF_W'(i_tri.ax);
        n_diff.e0y = bw_pkg::DIFF_W'(i_tri.by) - bw_pkg::DIFF_W'(i_tri.ay);
        n_diff.e1x = bw_pkg::DIFF_W'(i_tri.cx) - bw_pkg::DIFF_W'(i_tri.ax);
        n_diff.e1y = bw_pkg::DIFF_W'(i_tri.cy) - bw_pkg::DIFF_W'(i_tri.ay);
        n_diff.e2x = bw_pkg::DIFF_W'(i_tri.px) - bw_pkg::DIFF_W'(i_tri.ax);
        n_diff.e2y = bw_pkg::DIFF_W'(i_tri.py) - bw_pkg::DIFF_W'(i_tri.ay);
    end

    always_comb begin
        n_mags.ud    = bw_pkg::mag_of(r_sums.d);
        n_mags.ub    = bw_pkg::mag_of(r_sums.nb);
        n_mags.uc    = bw_pkg::mag_of(r_sums.nc);
        n_mags.neg_b = r_sums.nb[bw_pkg::SUM_W-1] ^ r_sums.d[bw_pkg::SUM_W-1];
        n_mags.neg_c = r_sums.nc[bw_pkg::SUM_W-1] ^ r_sums.d[bw_pkg::SUM_W-1];
        n_mags.degen = (r_sums.d == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
            if (rdy5) r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_diff <= n_diff;
        end
        if (rdy2) begin
            r_prod.p0 <= r_diff.e0x * r_diff.e1y;
            r_prod.p1 <= r_diff.e0y * r_diff.e1x;
            r_prod.p2 <= r_diff.e2x * r_diff.e1y;
            r_prod.p3 <= r_diff.e2y * r_diff.e1x;
            r_prod.p4 <= r_diff.e0x * r_diff.e2y;
            r_prod.p5 <= r_diff.e0y * r_diff.e2x;
        end
        if (rdy3) begin
            r_sums.d  <= bw_pkg::SUM_W'(r_prod.p0) - bw_pkg::SUM_W'(r_prod.p1);
            r_sums.nb <= bw_pkg::SUM_W'(r_prod.p2) - bw_pkg::SUM_W'(r_prod.p3);
            r_sums.nc <= bw_pkg::SUM_W'(r_prod.p4) - bw_pkg::SUM_W'(r_prod.p5);
        end
        if (rdy4) begin
            r_mags <= n_mags;
        end
        if (rdy5) begin
            r_div.lane_b <= bw_pkg::lane_init(r_mags.ub, r_mags.ud, r_mags.neg_b);
            r_div.lane_c <= bw_pkg::lane_init(r_mags.uc, r_mags.ud, r_mags.neg_c);
            r_div.ud     <= r_mags.ud;
            r_div.degen  <= r_mags.degen;
        end
    end

endmodule

// ===== rtl/core/bw_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bw_div
// Pipelined restoring divider, one quotient bit per stage for both lanes.
// ----------------------------------------------------------------------------
module bw_div (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  bw_pkg::t_div  i_div,
    output logic          o_valid,
    input  logic          i_ready,
    output bw_pkg::t_div  o_div
);

    logic         r_v [bw_pkg::DIV_STAGES];
    bw_pkg::t_div r_d [bw_pkg::DIV_STAGES];
    logic         rdy [bw_pkg::DIV_STAGES];

    genvar k;
    generate
        for (k = 0; k < bw_pkg::DIV_STAGES; k++) begin : g_stage
            logic         v_in;
            bw_pkg::t_div d_in;

            if (k == 0) begin : g_first
                assign v_in = i_valid;
                assign d_in = i_div;
            end else begin : g_next
                assign v_in = r_v[k-1];
                assign d_in = r_d[k-1];
            end

            if (k == bw_pkg::DIV_STAGES - 1) begin : g_last
                assign rdy[k] = !r_v[k] || i_ready;
            end else begin : g_mid
                assign rdy[k] = !r_v[k] || rdy[k+1];
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[k] <= 1'b0;
                end else if (rdy[k]) begin
                    r_v[k] <= v_in;
                end
            end

            always_ff @(posedge i_clk) begin
                if (rdy[k]) begin
                    r_d[k].lane_b <= bw_pkg::div_step(d_in.lane_b, d_in.ud);
                    r_d[k].lane_c <= bw_pkg::div_step(d_in.lane_c, d_in.ud);
                    r_d[k].ud     <= d_in.ud;
                    r_d[k].degen  <= d_in.degen;
                end
            end
        end
    endgenerate

    assign o_ready = rdy[0];
    assign o_valid = r_v[bw_pkg::DIV_STAGES-1];
    assign o_div   = r_d[bw_pkg::DIV_STAGES-1];

endmodule

// ===== rtl/core/bw_fin.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bw_fin
// Rounding, saturation, third weight and output register.
// ----------------------------------------------------------------------------
module bw_fin (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  bw_pkg::t_div                    i_div,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic signed [bw_pkg::WOUT_W-1:0] o_weight_a,
    output logic signed [bw_pkg::WOUT_W-1:0] o_weight_b,
    output logic signed [bw_pkg::WOUT_W-1:0] o_weight_c,
    output logic                            o_degenerate,
    output logic                            o_clipped
);

    logic                             r_v1, r_v2;
    logic                             rdy1, rdy2;
    bw_pkg::t_wt                      r_wt, n_wt;
    bw_pkg::t_sat                     sb, sc;
    logic signed [bw_pkg::WSUM_W-1:0] wsum;
    logic                             clip_a;
    logic signed [bw_pkg::WOUT_W-1:0] wa;
    logic signed [bw_pkg::WOUT_W-1:0] r_wa, r_wb, r_wc;
    logic                             r_degen, r_clip;

    assign rdy2    = !r_v2 || i_ready;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;

    always_comb begin
        sb         = bw_pkg::sat_quot(i_div.lane_b, i_div.ud);
        sc         = bw_pkg::sat_quot(i_div.lane_c, i_div.ud);
        n_wt.degen = i_div.degen;
        n_wt.wb    = i_div.degen ? '0 : sb.w;
        n_wt.wc    = i_div.degen ? '0 : sc.w;
        n_wt.clip  = !i_div.degen && (sb.clip || sc.clip);
    end

    always_comb begin
        wsum = bw_pkg::WEIGHT_ONE - bw_pkg::WSUM_W'(r_wt.wb) - bw_pkg::WSUM_W'(r_wt.wc);
        priority if (wsum > bw_pkg::WSUM_MAX) begin
            wa     = bw_pkg::WOUT_W'(bw_pkg::WSUM_MAX);
            clip_a = 1'b1;
        end else if (wsum < bw_pkg::WSUM_MIN) begin
            wa     = bw_pkg::WOUT_W'(bw_pkg::WSUM_MIN);
            clip_a = 1'b1;
        end else begin
            wa     = bw_pkg::WOUT_W'(wsum);
            clip_a = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_wt <= n_wt;
        end
        if (rdy2) begin
            r_wa    <= r_wt.degen ? '0 : wa;
            r_wb    <= r_wt.wb;
            r_wc    <= r_wt.wc;
            r_degen <= r_wt.degen;
            r_clip  <= r_wt.clip || (!r_wt.degen && clip_a);
        end
    end

    assign o_valid      = r_v2;
    assign o_weight_a   = r_wa;
    assign o_weight_b   = r_wb;
    assign o_weight_c   = r_wc;
    assign o_degenerate = r_degen;
    assign o_clipped    = r_clip;

endmodule

// ===== rtl/core/barycentric_weights_2d.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barycentric_weights_2d
// Barycentric weights of a query point against a 2D triangle.
//
// Input channel: i_valid / o_ready carries corners a, b, c and the query
// point as signed Q8.8. Output channel: o_valid / i_ready returns weights
// a, b, c as signed Q8.16 with degenerate and clipped flags, one result per
// request, in order.
// Stages run edge products and magnitudes, then the restoring divider
// (one quotient bit per stage for both quotients), then rounding,
// saturation and the third weight. Throughput is one request per cycle
// while the receiver accepts results.
// Each stage carries its own valid bit and loads whenever it is empty or the
// next stage moves, so bubbles collapse and new requests are taken while a
// result waits at the output. A stalled receiver fills the pipe; no request
// is lost or repeated.
// Reset clears all valid bits; no clearing pass is needed.
// ----------------------------------------------------------------------------
module barycentric_weights_2d (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic signed [bw_pkg::COORD_W-1:0] i_a_x,
    input  logic signed [bw_pkg::COORD_W-1:0] i_a_y,
    input  logic signed [bw_pkg::COORD_W-1:0] i_b_x,
    input  logic signed [bw_pkg::COORD_W-1:0] i_b_y,
    input  logic signed [bw_pkg::COORD_W-1:0] i_c_x,
    input  logic signed [bw_pkg::COORD_W-1:0] i_c_y,
    input  logic signed [bw_pkg::COORD_W-1:0] i_query_x,
    input  logic signed [bw_pkg::COORD_W-1:0] i_query_y,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic signed [bw_pkg::WOUT_W-1:0]  o_weight_a,
    output logic signed [bw_pkg::WOUT_W-1:0]  o_weight_b,
    output logic signed [bw_pkg::WOUT_W-1:0]  o_weight_c,
    output logic                             o_degenerate,
    output logic                             o_clipped
);

    bw_pkg::t_tri tri_in;
    bw_pkg::t_div geom_div, div_out;
    logic         geom_valid, geom_ready, div_valid, div_ready;

    assign tri_in.ax = i_a_x;
    assign tri_in.ay = i_a_y;
    assign tri_in.bx = i_b_x;
    assign tri_in.by = i_b_y;
    assign tri_in.cx = i_c_x;
    assign tri_in.cy = i_c_y;
    assign tri_in.px = i_query_x;
    assign tri_in.py = i_query_y;

    bw_geom u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_tri   (tri_in),
        .o_valid (geom_valid),
        .i_ready (geom_ready),
        .o_div   (geom_div)
    );

    bw_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (geom_valid),
        .o_ready (geom_ready),
        .i_div   (geom_div),
        .o_valid (div_valid),
        .i_ready (div_ready),
        .o_div   (div_out)
    );

    bw_fin u_fin (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (div_valid),
        .o_ready      (div_ready),
        .i_div        (div_out),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_weight_a   (o_weight_a),
        .o_weight_b   (o_weight_b),
        .o_weight_c   (o_weight_c),
        .o_degenerate (o_degenerate),
        .o_clipped    (o_clipped)
    );

    a_degen_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |->
            o_weight_a == '0 && o_weight_b == '0 && o_weight_c == '0 && !o_clipped)
        else $error("degenerate result with nonzero weights");

    a_weight_sum : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_degenerate && !o_clipped |->
            (bw_pkg::WSUM_W'(o_weight_a) + bw_pkg::WSUM_W'(o_weight_b)
             + bw_pkg::WSUM_W'(o_weight_c)) == bw_pkg::WEIGHT_ONE)
        else $error("weights do not sum to one");

    a_clip_limit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_clipped |->
            o_weight_a == bw_pkg::WOUT_W'(bw_pkg::WSUM_MAX)
            || o_weight_a == bw_pkg::WOUT_W'(bw_pkg::WSUM_MIN)
            || o_weight_b == bw_pkg::WOUT_W'(bw_pkg::WSUM_MAX)
            || o_weight_b == bw_pkg::WOUT_W'(bw_pkg::WSUM_MIN)
            || o_weight_c == bw_pkg::WOUT_W'(bw_pkg::WSUM_MAX)
            || o_weight_c == bw_pkg::WOUT_W'(bw_pkg::WSUM_MIN))
        else $error("clipped result with no weight at a limit");

endmodule
